// File: rtl/saturating_heat_map_with_palette_core_defines.svh
// assertion macros for the heat map checker
`ifndef SATURATING_HEAT_MAP_WITH_PALETTE_CORE_DEFINES_SVH
`define SATURATING_HEAT_MAP_WITH_PALETTE_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SHMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SHMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/shmp_pkg.sv
package shmp_pkg;

    // configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_MAP_WIDTH  = 2'd0;
    localparam cfg_idx_t CFG_MAP_HEIGHT = 2'd1;

    localparam logic [10:0] MAP_WIDTH_RESET  = 11'd576;
    localparam logic [10:0] MAP_HEIGHT_RESET = 11'd708;

    localparam logic [7:0] CELL_MAX  = 8'd255;
    localparam int         STEP_SIZE = 10;

    // palette intensities
    localparam logic [7:0] SHADE_DARK = 8'd85;
    localparam logic [7:0] SHADE_MID  = 8'd170;
    localparam logic [7:0] SHADE_FULL = 8'd255;

    // input word
    typedef struct packed {
        logic       mode;
        logic [9:0] x_coord;
        logic [9:0] y_coord;
        logic       alive;
    } shmp_in_t;

    // result word
    typedef struct packed {
        logic [7:0] cell_count;
        logic [3:0] level;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       painted;
        logic       out_of_range;
    } shmp_out_t;

    // per-stage control
    typedef struct packed {
        logic valid;
        logic oor;
        logic inc;
    } shmp_ctl_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } shmp_rgb_t;

    // clear sequencer states
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } shmp_state_t;

    // fixed palette: blue, green then red ramps; beyond the end stays full red
    function automatic shmp_rgb_t palette_lookup(input logic [3:0] idx);
        shmp_rgb_t rgb;
        case (idx)
            4'd0:    rgb = '{8'd0, 8'd0, SHADE_DARK};
            4'd1:    rgb = '{8'd0, 8'd0, SHADE_MID};
            4'd2:    rgb = '{8'd0, 8'd0, SHADE_FULL};
            4'd3:    rgb = '{8'd0, SHADE_DARK, 8'd0};
            4'd4:    rgb = '{8'd0, SHADE_MID, 8'd0};
            4'd5:    rgb = '{8'd0, SHADE_FULL, 8'd0};
            4'd6:    rgb = '{SHADE_DARK, 8'd0, 8'd0};
            4'd7:    rgb = '{SHADE_MID, 8'd0, 8'd0};
            default: rgb = '{SHADE_FULL, 8'd0, 8'd0};
        endcase
        return rgb;
    endfunction

endpackage

// File: rtl/shmp_addr.sv
module shmp_addr
    import shmp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int ADDR_W     = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              item_vld,
    input  shmp_in_t          item,
    input  logic [10:0]       map_width,
    input  logic [10:0]       map_height,
    output shmp_ctl_t         ctl,
    output logic [ADDR_W-1:0] addr
);

    logic [10:0]       w_eff;
    logic [10:0]       h_eff;
    logic              oor;
    logic [20:0]       lin;
    shmp_ctl_t         ctl_reg;
    shmp_ctl_t         ctl_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    // clamp the configured size to the storage
    assign w_eff = (32'(map_width) > MAX_WIDTH) ? 11'(MAX_WIDTH) : map_width;
    assign h_eff = (32'(map_height) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : map_height;

    // range check and linear address
    always_comb
    begin
        oor       = ({1'b0, item.x_coord} >= w_eff) || ({1'b0, item.y_coord} >= h_eff);
        lin       = 21'(item.y_coord) * 21'(w_eff) + 21'(item.x_coord);
        addr_next = ADDR_W'(lin);
        ctl_next  = '{valid: item_vld,
                      oor:   oor,
                      inc:   !oor && !item.mode && !item.alive};
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_next;
        end
    end

    // address register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr_reg <= addr_next;
        end
    end

    assign ctl  = ctl_reg;
    assign addr = addr_reg;

endmodule

// File: rtl/shmp_store.sv
module shmp_store
    import shmp_pkg::*;
#(
    parameter int DEPTH  = 1048576,
    parameter int ADDR_W = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    output logic [7:0]        rd_count,
    output logic              ready
);

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_q_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_data_reg;
    shmp_state_t       state_reg;
    shmp_state_t       state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clearing;
    logic              clr_last;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;

    assign clr_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));

    // clear sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:  state_next = ST_RUN;
            default: state_next = ST_CLEAR;
        endcase
    end

    // clear sequencer outputs
    always_comb
    begin
        clearing      = 1'b0;
        ready         = 1'b0;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing      = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_RUN:  ready = 1'b1;
            default: clearing = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // write port shared between the clearing pass and the update
    assign mem_we = clearing || wr_en;
    assign mem_wa = clearing ? clr_addr_reg : wr_addr;
    assign mem_wd = clearing ? 8'd0 : wr_data;

    // cell memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // bypass for a read of the cell written in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_count = fwd_hit_reg ? fwd_data_reg : rd_q_reg;

endmodule

// File: rtl/shmp_colour.sv
module shmp_colour
    import shmp_pkg::*;
#(
    parameter int LEVELS = 9
)
(
    input  logic [7:0] count,
    input  logic       oor,
    output shmp_out_t  res
);

    logic [3:0] lvl;
    shmp_rgb_t  rgb;

    // first threshold at or above the count, else the top level
    always_comb
    begin
        lvl = 4'(LEVELS - 1);
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (32'(count) <= STEP_SIZE * (i + 1))
            begin
                lvl = 4'(i);
            end
        end
    end

    assign rgb = palette_lookup(lvl);

    // assemble the result word; out of range and empty cells report zeros
    always_comb
    begin
        res = '0;
        if (oor)
        begin
            res.out_of_range = 1'b1;
        end
        else
        begin
            res.cell_count = count;
            if (count != 8'd0)
            begin
                res.level   = lvl;
                res.red     = rgb.red;
                res.green   = rgb.green;
                res.blue    = rgb.blue;
                res.painted = 1'b1;
            end
        end
    end

endmodule

// File: rtl/saturating_heat_map_with_palette_core.sv
// channel  | direction | handshake                   | word
// item     | in        | item_valid / item_stall     | shmp_in_t
// result   | out       | result_valid / result_stall | shmp_out_t
// config   | in        | cfg_we, cfg_index           | cfg_data (11 bits)
//
// every word yields one result word, passed through the input, address, update and output registers
// one word per cycle sustained unless the pipeline is stalled; the cell read-modify-write loop with bypass sets this
// after reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells (1048576 by default)
// zeroes the memory while item_stall stays high
// result_stall with a valid result freezes the whole pipeline, so the item side stalls with it
module saturating_heat_map_with_palette_core
    import shmp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int LEVELS     = 9
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  shmp_in_t    item_word,
    output logic        result_valid,
    input  logic        result_stall,
    output shmp_out_t   result_word,
    input  logic        cfg_we,
    input  cfg_idx_t    cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              adv;
    logic              store_ready;
    logic              accept;
    logic [10:0]       map_width_reg;
    logic [10:0]       map_height_reg;
    logic              p1_valid_reg;
    shmp_in_t          p1_item_reg;
    shmp_ctl_t         p2_ctl;
    logic [ADDR_W-1:0] p2_addr;
    shmp_ctl_t         p3_ctl_reg;
    logic [ADDR_W-1:0] p3_addr_reg;
    logic              rd_en;
    logic              wr_en;
    logic [7:0]        old_count;
    logic [7:0]        new_count;
    shmp_out_t         res_next;
    logic              result_valid_reg;
    shmp_out_t         result_reg;

    // pipeline moves unless a finished word is held back
    assign adv        = !(result_valid_reg && result_stall);
    assign item_stall = !adv || !store_ready;
    assign accept     = item_valid && !item_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= MAP_WIDTH_RESET;
            map_height_reg <= MAP_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                CFG_MAP_HEIGHT: map_height_reg <= cfg_data;
                default:        map_width_reg  <= map_width_reg;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_item_reg <= item_word;
        end
    end

    // range check and address stage
    shmp_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_vld   (p1_valid_reg),
        .item       (p1_item_reg),
        .map_width  (map_width_reg),
        .map_height (map_height_reg),
        .ctl        (p2_ctl),
        .addr       (p2_addr)
    );

    // read issue, data lands with the update stage
    assign rd_en = adv && p2_ctl.valid && !p2_ctl.oor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_ctl_reg <= '0;
        end
        else if (adv)
        begin
            p3_ctl_reg <= p2_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_addr_reg <= p2_addr;
        end
    end

    // saturating increment and write-back
    assign new_count = (p3_ctl_reg.inc && (old_count != CELL_MAX)) ?
                       old_count + 8'd1 : old_count;
    assign wr_en     = adv && p3_ctl_reg.valid && !p3_ctl_reg.oor;

    shmp_store #(
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (p2_addr),
        .wr_en    (wr_en),
        .wr_addr  (p3_addr_reg),
        .wr_data  (new_count),
        .rd_count (old_count),
        .ready    (store_ready)
    );

    // classification and palette
    shmp_colour #(
        .LEVELS (LEVELS)
    ) u_colour (
        .count (new_count),
        .oor   (p3_ctl_reg.oor),
        .res   (res_next)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= p3_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= res_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_reg;

endmodule

// File: rtl/shmp_checker.sv
`include "saturating_heat_map_with_palette_core_defines.svh"

module shmp_checker
    import shmp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_stall,
    input shmp_out_t result_word
);

    // a held result word stays put
    `SHMP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_word), "result word changed while stalled")

    // out of range words carry nothing else
    `SHMP_ASSERT_NOW(a_oor_clean, result_valid && result_word.out_of_range, (result_word.cell_count == 8'd0) && !result_word.painted && (result_word.level == 4'd0), "out of range word not cleared")

    // painted exactly when the count is non-zero
    `SHMP_ASSERT_NOW(a_painted, result_valid, result_word.painted == (result_word.cell_count != 8'd0), "painted flag disagrees with count")

    // unpainted words have no colour
    `SHMP_ASSERT_NOW(a_no_colour, result_valid && !result_word.painted, (result_word.red == 8'd0) && (result_word.green == 8'd0) && (result_word.blue == 8'd0) && (result_word.level == 4'd0), "colour on an unpainted word")

endmodule

bind saturating_heat_map_with_palette_core shmp_checker u_shmp_checker (.*);
